>>> hdl/mts_pkg.sv
package mts_pkg;

  // stack geometry
  localparam int unsigned Depth  = 1024;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned EntryCountW = 11;

  // stream word widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 80;

  // operation codes
  localparam logic [1:0] OpPush  = 2'd0;
  localparam logic [1:0] OpPop   = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  // error codes
  localparam logic [1:0] ErrOk       = 2'd0;
  localparam logic [1:0] ErrPopEmpty = 2'd1;
  localparam logic [1:0] ErrPushFull = 2'd2;

  // readings of an empty stack
  localparam logic signed [DataW-1:0] EmptyTop = -32'sd1;
  localparam logic signed [DataW-1:0] EmptyMin = 32'sh7FFF_FFFF;

  // one stack slot: stored value and minimum of it and everything below
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] run_min;
  } entry_t;

  // shift command broadcast along the chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

>>> hdl/min_tracking_stack.sv
// Bounded stack of signed 32-bit values that reports its top and the minimum
// of all held entries. Each input word is a push, a pop or a query, and each
// produces exactly one result word: top after the step (-1 when empty),
// minimum after the step (2147483647 when empty), entry count and an error
// code (1 for pop on empty, 2 for push on full; the stack is then unchanged).
// The stack is a row of 1024 shift cells; each cell holds a value and the
// running minimum of it and all entries below, so every result is read from
// the top two cells alone, while a push or a pop shifts the whole row at
// once. One word is taken per cycle while the output register is free; the
// result is registered in an output register on acceptance, and a new word is
// accepted whenever that register is empty or being drained in the same
// cycle. Unused op code 3 acts as a query.
module min_tracking_stack (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // op [1:0], value [33:2], zero [39:34]
  input  logic [mts_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // top_value [31:0], min_value [63:32], entry_count [74:64], error [76:75],
  // zero [79:77]
  output logic [mts_pkg::OutDataW-1:0] m_axis_tdata
);
  import mts_pkg::*;

  logic [1:0]              in_op;
  logic signed [DataW-1:0] in_value;
  logic                    in_fire;
  logic                    out_fire;

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;

  shift_ctrl_t ctrl;
  entry_t      push_entry;
  entry_t      top_entry;
  entry_t      second_entry;
  logic signed [DataW-1:0] below_min;

  logic signed [DataW-1:0]   res_top;
  logic signed [DataW-1:0]   res_min;
  logic [1:0]                res_err;

  logic                      out_valid_q;
  logic                      out_valid_d;
  logic signed [DataW-1:0]   out_top_q;
  logic signed [DataW-1:0]   out_min_q;
  logic [EntryCountW-1:0]    out_count_q;
  logic [1:0]                out_err_q;

  // unpack input word
  assign in_op    = s_axis_tdata[1:0];
  assign in_value = s_axis_tdata[DataW+1:2];

  // handshakes
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  // new entry carries its own running minimum
  assign below_min          = (count_q != '0) ? top_entry.run_min : EmptyMin;
  assign push_entry.value   = in_value;
  assign push_entry.run_min = (in_value < below_min) ? in_value : below_min;

  // decode operation, pick next count and the result fields
  always_comb begin
    ctrl    = '0;
    count_d = count_q;
    res_err = ErrOk;
    res_top = (count_q != '0) ? top_entry.value : EmptyTop;
    res_min = (count_q != '0) ? top_entry.run_min : EmptyMin;
    case (in_op)
      OpPush: begin
        if (count_q == CountW'(Depth)) begin
          res_err = ErrPushFull;
        end else begin
          ctrl.push = in_fire;
          count_d   = count_q + CountW'(1);
          res_top   = push_entry.value;
          res_min   = push_entry.run_min;
        end
      end
      OpPop: begin
        if (count_q == '0) begin
          res_err = ErrPopEmpty;
        end else begin
          ctrl.pop = in_fire;
          count_d  = count_q - CountW'(1);
          if (count_q == CountW'(1)) begin
            res_top = EmptyTop;
            res_min = EmptyMin;
          end else begin
            res_top = second_entry.value;
            res_min = second_entry.run_min;
          end
        end
      end
      default: begin
        // query leaves the stack as it is
      end
    endcase
  end

  // chain of stack cells
  mts_cell_chain u_chain (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .push_entry_i (push_entry),
    .top_o        (top_entry),
    .second_o     (second_entry)
  );

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_fire) begin
      count_q <= count_d;
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_top_q   <= res_top;
      out_min_q   <= res_min;
      out_count_q <= EntryCountW'(count_d);
      out_err_q   <= res_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_err_q, out_count_q, out_min_q, out_top_q};

  // the count never passes the stack depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("entry count beyond stack depth");

  // a successful push lands in the top cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_op == OpPush && count_q != CountW'(Depth))
      |=> (top_entry.value == $past(in_value)))
    else $error("pushed value missing from top cell");

  // the running minimum of the top never exceeds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (top_entry.run_min <= top_entry.value))
    else $error("running minimum above top value");

  // a pop-on-empty result always reports an empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q == ErrPopEmpty) |-> (out_count_q == '0))
    else $error("pop on empty reported with entries held");

endmodule

>>> hdl/mts_cell.sv
module mts_cell (
  input  logic                clk_i,
  input  mts_pkg::shift_ctrl_t ctrl_i,
  input  mts_pkg::entry_t     upper_i,
  input  mts_pkg::entry_t     lower_i,
  output mts_pkg::entry_t     entry_o
);
  import mts_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // push moves entries one slot deeper, pop moves them one slot up
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      entry_d = upper_i;
    end else if (ctrl_i.pop) begin
      entry_d = lower_i;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> hdl/mts_cell_chain.sv
module mts_cell_chain (
  input  logic                 clk_i,
  input  mts_pkg::shift_ctrl_t ctrl_i,
  input  mts_pkg::entry_t      push_entry_i,
  output mts_pkg::entry_t      top_o,
  output mts_pkg::entry_t      second_o
);
  import mts_pkg::*;

  entry_t cell_entry [Depth];

  // row of cells, slot zero is the top of stack
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    entry_t upper;
    entry_t lower;

    if (i == 0) begin : g_first
      assign upper = push_entry_i;
    end else begin : g_mid_up
      assign upper = cell_entry[i-1];
    end

    // the deepest slot keeps its content on pop, it is never read again
    if (i == Depth - 1) begin : g_last
      assign lower = cell_entry[i];
    end else begin : g_mid_dn
      assign lower = cell_entry[i+1];
    end

    mts_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .upper_i (upper),
      .lower_i (lower),
      .entry_o (cell_entry[i])
    );
  end

  assign top_o    = cell_entry[0];
  assign second_o = cell_entry[1];

endmodule

>>> test/tb_min_tracking_stack.sv
module tb_min_tracking_stack;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  // op code 3 is not named in the package, the block treats it as a query
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic signed [DataW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] ValMin = 32'sh8000_0000;

  localparam int unsigned CycleLimit = 400000;

  // one result word, unpacked into its fields
  typedef struct {
    logic signed [DataW-1:0] top;
    logic signed [DataW-1:0] low;
    logic [EntryCountW-1:0]  count;
    logic [1:0]              err;
  } stack_view_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // predicted stack contents
  logic signed [DataW-1:0] value_mem   [Depth];
  logic signed [DataW-1:0] run_min_mem [Depth];
  int unsigned             held = 0;

  stack_view_t pending_views[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  bit          no_gaps     = 1'b0;

  min_tracking_stack dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one operation to the predicted stack and return what the block should report
  function automatic stack_view_t next_stack_view(input logic [1:0] op,
                                                  input logic signed [DataW-1:0] value);
    stack_view_t             view;
    logic signed [DataW-1:0] below;
    view.err = ErrOk;
    if (op == OpPush) begin
      if (held == Depth) begin
        view.err = ErrPushFull;
      end else begin
        below = (held > 0) ? run_min_mem[held-1] : EmptyMin;
        value_mem[held]   = value;
        run_min_mem[held] = (value < below) ? value : below;
        held++;
      end
    end else if (op == OpPop) begin
      if (held == 0) view.err = ErrPopEmpty;
      else held--;
    end
    view.top   = (held > 0) ? value_mem[held-1] : EmptyTop;
    view.low   = (held > 0) ? run_min_mem[held-1] : EmptyMin;
    view.count = held[EntryCountW-1:0];
    return view;
  endfunction

  // mostly wide random values, with extremes and a narrow band that repeats minima
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return ValMax;
      1: return ValMin;
      2: return -32'sd1;
      3: return 32'sd0;
      4: return int'($urandom_range(0, 15)) - 8;
      default: return $urandom();
    endcase
  endfunction

  // offer one word after a random gap and record its prediction once taken
  task automatic send_word(input logic [1:0] op, input logic signed [DataW-1:0] value);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-DataW-2){1'b0}}, value, op};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pending_views.push_back(next_stack_view(op, value));
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain_outputs();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_field(input string field, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s mismatch: expected %0d, got %0d", field, want, got);
  endtask

  // pop, query and unused op on an empty stack
  task automatic test_empty_stack();
    send_word(OpPop, pick_value());
    send_word(OpQuery, ValMin);
    send_word(OpUnused, ValMax);
    drain_outputs();
  endtask

  // extreme values, a repeated minimum, then pop everything and one more
  task automatic test_value_extremes();
    send_word(OpPush, ValMax);
    send_word(OpPush, ValMin);
    send_word(OpPush, -32'sd1);
    send_word(OpPush, 32'sd0);
    send_word(OpPush, 32'sd1);
    send_word(OpPush, 32'sh5555_5555);
    send_word(OpPush, 32'shAAAA_AAAA);
    send_word(OpPush, ValMin);
    send_word(OpQuery, -32'sd1);
    send_word(OpUnused, 32'sh5555_5555);
    repeat (9) send_word(OpPop, 32'shAAAA_AAAA);
    drain_outputs();
  endtask

  // fill to capacity, push on full, then empty it again
  task automatic test_fill_to_full();
    no_gaps = 1'b1;
    for (int n = 0; n < Depth; n++) begin
      if (n == Depth / 2) no_gaps = 1'b0;
      send_word(OpPush, pick_value());
    end
    send_word(OpPush, ValMin);
    send_word(OpPush, pick_value());
    send_word(OpQuery, 32'sd0);
    send_word(OpPop, 32'sd0);
    send_word(OpPush, ValMin);
    send_word(OpPush, ValMax);
    for (int n = 0; n <= Depth; n++) begin
      no_gaps = (n < Depth / 2);
      send_word(OpPop, pick_value());
    end
    no_gaps = 1'b0;
    drain_outputs();
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_output_backpressure();
    no_gaps   = 1'b1;
    hold_left = 300;
    for (int n = 0; n < 24; n++) begin
      send_word((n % 3 == 2) ? OpPop : ((n % 5 == 4) ? OpQuery : OpPush), pick_value());
    end
    no_gaps = 1'b0;
    drain_outputs();
  endtask

  // random walk of the stack depth with growing and shrinking phases
  task automatic test_random_traffic();
    bit          growing;
    int unsigned roll;
    logic [1:0]  op;
    growing = 1'b1;
    for (int n = 0; n < 650; n++) begin
      if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
      if (held == 0) growing = 1'b1;
      else if (held >= 160) growing = 1'b0;
      else if ($urandom_range(0, 59) == 0) growing = !growing;
      roll = $urandom_range(0, 99);
      if (roll < (growing ? 60 : 25)) op = OpPush;
      else if (roll < 88) op = OpPop;
      else if (roll < 96) op = OpQuery;
      else op = OpUnused;
      send_word(op, pick_value());
    end
    no_gaps = 1'b0;
    drain_outputs();
  endtask

  // result side ready, with random stalls and the long hold-off
  initial begin : drive_ready
    int unsigned wait_left;
    wait_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (wait_left != 0) begin
        wait_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) wait_left = no_gaps ? 0 : $urandom_range(0, 19);
    end
  end

  // compare each result word against the oldest prediction
  always @(posedge clk_i) begin : check_results
    stack_view_t got;
    stack_view_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.top   = m_axis_tdata[DataW-1:0];
      got.low   = m_axis_tdata[2*DataW-1:DataW];
      got.count = m_axis_tdata[2*DataW +: EntryCountW];
      got.err   = m_axis_tdata[2*DataW+EntryCountW +: 2];
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: top %0d min %0d count %0d error %0d",
                   got.top, got.low, got.count, got.err);
      end else begin
        want = pending_views.pop_front();
        if (got.top !== want.top) report_field("top_value", want.top, got.top);
        if (got.low !== want.low) report_field("min_value", want.low, got.low);
        if (got.count !== want.count) report_field("entry_count", want.count, got.count);
        if (got.err !== want.err) report_field("error", want.err, got.err);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb_min_tracking_stack: errors");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_stack();
    test_value_extremes();
    test_fill_to_full();
    test_output_backpressure();
    test_random_traffic();

    // let any stray word show up before the verdict
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_views.size() == 0)
      $display("tb_min_tracking_stack: clean");
    else
      $display("tb_min_tracking_stack: errors");
    $finish;
  end

endmodule
